/* sv/tas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tas_pkg
// Shared types and constants of the three-axis slew-limited stage.
// ----------------------------------------------------------------------------
package tas_pkg;

  // axis count and coordinate format
  localparam int NUM_AXES    = 3;
  localparam int COORD_W     = 32;
  localparam int RATE_W      = 32;
  localparam int ELAPSED_W   = 20;
  localparam int PROD_W      = ELAPSED_W + RATE_W;
  localparam int FRAC_W      = 16;
  localparam int AXIS_X      = 0;
  localparam int AXIS_Y      = 1;
  localparam int AXIS_Z      = 2;

  // stream packing
  localparam int ACTION_W    = 2;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 200;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LATERAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_FOCUS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_X_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_X_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_Y_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_Y_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_Z_LOW    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_Z_HIGH   = 3'd7;

  // reset values of the limit registers
  localparam logic signed [COORD_W-1:0] LIM_LOW_RST  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] LIM_HIGH_RST = {1'b0, {(COORD_W-1){1'b1}}};

  // request kinds
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_SET  = 2'd2,
    ACT_IDLE = 2'd3
  } action_t;

  // control shared by all lanes in the update stage
  typedef struct packed {
    logic    adv;
    action_t action;
  } lane_ctrl_t;

endpackage

/* sv/three_axis_slew_limited_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_slew_limited_stage
// Simulated three-axis stage with a slew-rate limit per axis.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : requests; in_tuser carries the kind (tick, move, set, idle), in_tdata
//           the elapsed time and the three coordinates.
//   out_* : one result per request: positions, targets and the moved flag.
//   cfg_* : register writes, to be made only while no request is in flight;
//           the block itself does not enforce this. Throughput is one request
// per cycle unless the receiver stalls: the first stage computes each lane's
// allowance with one 20x32 multiplier and its clamped target, the second stage
// updates the axis state with three subtracts, one add and compares per lane.
// The state registers themselves form the output register, so a result is
// held while the receiver stalls; one further request waits in the first
// stage and in_tready drops only when both are full.
// Reset (rst_n low, synchronous) zeroes positions and targets, clears the
// rates and opens the limits to the full coordinate range.
// ----------------------------------------------------------------------------
module three_axis_slew_limited_stage import tas_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,   // elapsed_us, coord_x, coord_y, coord_z, zero pad
  input  logic [ACTION_W-1:0]     in_tuser,   // action
  // result channel
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,  // pos_x, pos_y, pos_z, goal_x, goal_y, goal_z, moved, pad
  // configuration writes
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_W-1:0]      cfg_wdata
);

  logic [RATE_W-1:0]          rate_lat_r, rate_foc_r;
  logic signed [COORD_W-1:0]  lim_low_r  [NUM_AXES];
  logic signed [COORD_W-1:0]  lim_high_r [NUM_AXES];
  logic signed [COORD_W-1:0]  coord      [NUM_AXES];
  logic signed [COORD_W-1:0]  pos        [NUM_AXES];
  logic signed [COORD_W-1:0]  goal       [NUM_AXES];
  logic [NUM_AXES-1:0]        lane_moved;
  logic [ELAPSED_W-1:0]       elapsed_us;
  logic                       s1_valid_r, s1_valid_nxt;
  action_t                    s1_action_r;
  logic                       in_acc, out_free, s1_adv, moved;
  lane_ctrl_t                 ctrl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_lat_r <= '0;
      rate_foc_r <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        lim_low_r[i]  <= LIM_LOW_RST;
        lim_high_r[i] <= LIM_HIGH_RST;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RATE_LATERAL: rate_lat_r         <= cfg_wdata;
        REG_RATE_FOCUS:   rate_foc_r         <= cfg_wdata;
        REG_LIM_X_LOW:    lim_low_r[AXIS_X]  <= $signed(cfg_wdata);
        REG_LIM_X_HIGH:   lim_high_r[AXIS_X] <= $signed(cfg_wdata);
        REG_LIM_Y_LOW:    lim_low_r[AXIS_Y]  <= $signed(cfg_wdata);
        REG_LIM_Y_HIGH:   lim_high_r[AXIS_Y] <= $signed(cfg_wdata);
        REG_LIM_Z_LOW:    lim_low_r[AXIS_Z]  <= $signed(cfg_wdata);
        REG_LIM_Z_HIGH:   lim_high_r[AXIS_Z] <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // request unpacking
  assign elapsed_us      = in_tdata[ELAPSED_W-1:0];
  assign coord[AXIS_X]   = $signed(in_tdata[ELAPSED_W +: COORD_W]);
  assign coord[AXIS_Y]   = $signed(in_tdata[ELAPSED_W+COORD_W +: COORD_W]);
  assign coord[AXIS_Z]   = $signed(in_tdata[ELAPSED_W+2*COORD_W +: COORD_W]);

  // two-stage flow control
  assign out_free  = !out_tvalid || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= action_t'(in_tuser);
    end
  end

  assign ctrl.adv    = s1_adv;
  assign ctrl.action = s1_action_r;

  // one lane per axis; X and Y share the lateral rate
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    tas_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .load       (in_acc),
      .ctrl       (ctrl),
      .elapsed_us (elapsed_us),
      .rate       ((g == AXIS_Z) ? rate_foc_r : rate_lat_r),
      .coord      (coord[g]),
      .lim_low    (lim_low_r[g]),
      .lim_high   (lim_high_r[g]),
      .pos        (pos[g]),
      .goal       (goal[g]),
      .moved      (lane_moved[g])
    );
  end

  // merge of lane results
  tas_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (s1_adv),
    .out_tready (out_tready),
    .lane_moved (lane_moved),
    .out_valid  (out_tvalid),
    .moved      (moved)
  );

  // result packing
  assign out_tdata = {7'b0, moved,
                      goal[AXIS_Z], goal[AXIS_Y], goal[AXIS_X],
                      pos[AXIS_Z], pos[AXIS_Y], pos[AXIS_X]};

`ifndef ASSERT_OFF
  // an advancing request always leaves a valid result
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid)
    else $error("result not valid after update");

  // a set leaves every axis at its target
  a_set_settles: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_action_r == ACT_SET)) |=>
      ((pos[AXIS_X] == goal[AXIS_X]) && (pos[AXIS_Y] == goal[AXIS_Y]) &&
       (pos[AXIS_Z] == goal[AXIS_Z]) && !moved))
    else $error("set left an axis off target");

  // no request is taken while both stages are full and stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && s1_valid_r && out_tvalid && !out_tready))
    else $error("request taken into a full pipeline");
`endif

endmodule

/* sv/tas_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tas_lane
// One axis: step allowance and target clamp in the first stage, then the
// position and target update in the second.
// ----------------------------------------------------------------------------
module tas_lane import tas_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  lane_ctrl_t                  ctrl,
  input  logic [ELAPSED_W-1:0]        elapsed_us,
  input  logic [RATE_W-1:0]           rate,
  input  logic signed [COORD_W-1:0]   coord,
  input  logic signed [COORD_W-1:0]   lim_low,
  input  logic signed [COORD_W-1:0]   lim_high,
  output logic signed [COORD_W-1:0]   pos,
  output logic signed [COORD_W-1:0]   goal,
  output logic                        moved
);

  logic [PROD_W-1:0]          prod;
  logic [COORD_W-1:0]         step_nxt, step_r;
  logic signed [COORD_W-1:0]  clamp_nxt, clamp_r;
  logic signed [COORD_W-1:0]  coord_r;
  logic signed [COORD_W-1:0]  pos_r, pos_nxt;
  logic signed [COORD_W-1:0]  goal_r, goal_nxt;
  logic signed [COORD_W:0]    diff_pt, diff_tp;
  logic                       pos_above;
  logic [COORD_W-1:0]         span;

  // allowance: product with fraction dropped, saturated to 32 bits
  assign prod = PROD_W'(elapsed_us) * PROD_W'(rate);

  always_comb begin
    if (|prod[PROD_W-1:FRAC_W+COORD_W]) begin
      step_nxt = '1;
    end else begin
      step_nxt = prod[FRAC_W+COORD_W-1:FRAC_W];
    end
  end

  // target clamp, low bound tested first
  always_comb begin
    if (coord < lim_low) begin
      clamp_nxt = lim_low;
    end else if (coord > lim_high) begin
      clamp_nxt = lim_high;
    end else begin
      clamp_nxt = coord;
    end
  end

  // first stage registers
  always_ff @(posedge clk) begin
    if (load) begin
      step_r  <= step_nxt;
      clamp_r <= clamp_nxt;
      coord_r <= coord;
    end
  end

  // exact distance between position and target
  assign diff_pt   = {pos_r[COORD_W-1], pos_r} - {goal_r[COORD_W-1], goal_r};
  assign diff_tp   = {goal_r[COORD_W-1], goal_r} - {pos_r[COORD_W-1], pos_r};
  assign pos_above = pos_r > goal_r;
  assign span      = pos_above ? diff_pt[COORD_W-1:0] : diff_tp[COORD_W-1:0];

  // state update
  always_comb begin
    pos_nxt  = pos_r;
    goal_nxt = goal_r;
    unique case (ctrl.action)
      ACT_TICK: begin
        if (pos_r != goal_r) begin
          if (span < step_r) begin
            pos_nxt = goal_r;
          end else if (pos_above) begin
            pos_nxt = pos_r - $signed(step_r);
          end else begin
            pos_nxt = pos_r + $signed(step_r);
          end
        end
      end
      ACT_MOVE: begin
        goal_nxt = clamp_r;
      end
      ACT_SET: begin
        pos_nxt  = coord_r;
        goal_nxt = coord_r;
      end
      ACT_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      goal_r <= '0;
    end else if (ctrl.adv) begin
      pos_r  <= pos_nxt;
      goal_r <= goal_nxt;
    end
  end

  assign pos   = pos_r;
  assign goal  = goal_r;
  assign moved = (ctrl.action == ACT_TICK) && (pos_r != goal_r);

endmodule

/* sv/tas_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tas_merge
// Combines the per-lane motion flags and holds the result valid flag.
// ----------------------------------------------------------------------------
module tas_merge import tas_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                out_tready,
  input  logic [NUM_AXES-1:0] lane_moved,
  output logic                out_valid,
  output logic                moved
);

  logic out_valid_r, out_valid_nxt;
  logic moved_r;

  // result stays valid until taken, refilled by each advancing request
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // any lane away from its target
  always_ff @(posedge clk) begin
    if (adv) begin
      moved_r <= |lane_moved;
    end
  end

  assign out_valid = out_valid_r;
  assign moved     = moved_r;

endmodule

/* bench/stage_motion_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stage_motion_checker
// Watches the request, result and register-write ports of the three-axis
// stage, keeps its own copy of the axis state and the register file, predicts
// positions, targets and the moved flag for every accepted request, and
// compares each returned result field by field in arrival order.
// ----------------------------------------------------------------------------
module stage_motion_checker import tas_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [ACTION_W-1:0]    in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0]     cfg_wdata,
  output int                     error_count,
  output int                     outstanding
);

  typedef logic signed [COORD_W-1:0] coord_t;

  // result layout, lowest bits first: pos x/y/z, goal x/y/z, moved
  typedef struct packed {
    logic                                moved;
    logic [NUM_AXES-1:0][COORD_W-1:0]    goal;
    logic [NUM_AXES-1:0][COORD_W-1:0]    pos;
  } stage_view_t;

  logic [RATE_W-1:0] rate_lateral_q;
  logic [RATE_W-1:0] rate_focus_q;
  coord_t            lim_low  [NUM_AXES];
  coord_t            lim_high [NUM_AXES];
  coord_t            position [NUM_AXES];
  coord_t            target   [NUM_AXES];
  stage_view_t       expected_views [$];
  string             axis_tag [NUM_AXES] = '{"x", "y", "z"};
  int                fail_tally = 0;

  assign error_count = fail_tally;

  // low bound is tested first, so with crossed limits a value below low resolves to low, any other to high
  function automatic coord_t clamp_axis(coord_t v, coord_t lo, coord_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one tick of a single axis that is away from its target
  function automatic coord_t slew_axis(coord_t p, coord_t t, logic [RATE_W-1:0] rate,
                                       logic [ELAPSED_W-1:0] elapsed);
    logic [PROD_W-1:0]       prod;
    logic [COORD_W-1:0]      allow;
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        span;
    prod  = PROD_W'(elapsed) * PROD_W'(rate);
    // drop the fraction, saturate anything beyond 32 bits
    allow = (prod[PROD_W-1:FRAC_W+COORD_W] != '0) ? '1
                                                  : prod[FRAC_W+COORD_W-1:FRAC_W];
    diff  = {p[COORD_W-1], p} - {t[COORD_W-1], t};
    span  = diff[COORD_W] ? -diff : diff;
    if (span < {1'b0, allow}) return t;
    if (t < p) return p - allow;
    return p + allow;
  endfunction

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_tally++;
  endtask

  task automatic check_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
    if (got !== want)
      report($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  always @(posedge clk) begin
    stage_view_t          want;
    stage_view_t          got;
    action_t              act;
    coord_t               coord [NUM_AXES];
    logic [ELAPSED_W-1:0] elapsed;
    logic                 moved;
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        lim_low[i]  = LIM_LOW_RST;
        lim_high[i] = LIM_HIGH_RST;
        position[i] = '0;
        target[i]   = '0;
      end
      rate_lateral_q = '0;
      rate_focus_q   = '0;
      expected_views.delete();
      outstanding <= 0;
    end else begin
      // register writes are to be made only while idle; the checker does not enforce it
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RATE_LATERAL: rate_lateral_q = cfg_wdata;
          REG_RATE_FOCUS:   rate_focus_q   = cfg_wdata;
          REG_LIM_X_LOW:    lim_low[AXIS_X]  = cfg_wdata;
          REG_LIM_X_HIGH:   lim_high[AXIS_X] = cfg_wdata;
          REG_LIM_Y_LOW:    lim_low[AXIS_Y]  = cfg_wdata;
          REG_LIM_Y_HIGH:   lim_high[AXIS_Y] = cfg_wdata;
          REG_LIM_Z_LOW:    lim_low[AXIS_Z]  = cfg_wdata;
          REG_LIM_Z_HIGH:   lim_high[AXIS_Z] = cfg_wdata;
          default: ;
        endcase
      end

      // returned result against the oldest prediction
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(stage_view_t)-1:0];
        if (expected_views.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          want = expected_views.pop_front();
          for (int i = 0; i < NUM_AXES; i++) begin
            check_field({"pos_", axis_tag[i]}, got.pos[i], want.pos[i]);
            check_field({"goal_", axis_tag[i]}, got.goal[i], want.goal[i]);
          end
          check_field("moved", COORD_W'(got.moved), COORD_W'(want.moved));
        end
      end

      // accepted request: update the axis state and queue the result
      if (in_tvalid && in_tready) begin
        act     = action_t'(in_tuser);
        elapsed = in_tdata[ELAPSED_W-1:0];
        for (int i = 0; i < NUM_AXES; i++)
          coord[i] = in_tdata[ELAPSED_W + COORD_W*i +: COORD_W];
        moved = 1'b0;
        case (act)
          ACT_TICK: begin
            for (int i = 0; i < NUM_AXES; i++) begin
              if (position[i] != target[i]) begin
                moved       = 1'b1;
                position[i] = slew_axis(position[i], target[i],
                                        (i == AXIS_Z) ? rate_focus_q : rate_lateral_q,
                                        elapsed);
              end
            end
          end
          ACT_MOVE: begin
            for (int i = 0; i < NUM_AXES; i++)
              target[i] = clamp_axis(coord[i], lim_low[i], lim_high[i]);
          end
          ACT_SET: begin
            for (int i = 0; i < NUM_AXES; i++) begin
              position[i] = coord[i];
              target[i]   = coord[i];
            end
          end
          default: ;
        endcase
        for (int i = 0; i < NUM_AXES; i++) begin
          want.pos[i]  = position[i];
          want.goal[i] = target[i];
        end
        want.moved = moved;
        expected_views.push_back(want);
      end
      outstanding <= expected_views.size();
    end
  end

endmodule

/* bench/tb_three_axis_slew_limited_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_axis_slew_limited_stage
// Drives tick, move, set and unused requests into the three-axis stage under
// several register settings, with random idling on both stream sides and
// long result hold-offs that back the block up; a separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_three_axis_slew_limited_stage import tas_pkg::*;;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam int CYCLE_LIMIT       = 200000;
  localparam int ITEMS_PER_SEGMENT = 158;
  localparam int SETTLE_CYCLES     = 6;
  localparam int HOLD_CYCLES       = 64;
  localparam int HOLD_SPACING      = 400;

  localparam coord_t               CMIN        = LIM_LOW_RST;
  localparam coord_t               CMAX        = LIM_HIGH_RST;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [RATE_W-1:0]    RATE_MAX    = '1;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // elapsed_us, coord_x, coord_y, coord_z, pad
  logic [ACTION_W-1:0]    in_tuser   = '0;   // action
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // pos x/y/z, goal x/y/z, moved, pad
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [COORD_W-1:0]     cfg_wdata  = '0;

  int error_count;
  int outstanding;
  int tx_idle_pct    = 9;
  int rx_idle_pct    = 59;
  int accepted_count = 0;
  int hold_left      = 0;
  int next_hold_at   = 300;
  int cycle_count    = 0;

  three_axis_slew_limited_stage DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  stage_motion_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // reset at start-up, then released
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // accepted request count, drives the hold-off points
  always @(posedge clk) begin
    if (!rst_n)
      accepted_count <= 0;
    else if (in_tvalid && in_tready)
      accepted_count <= accepted_count + 1;
  end

  // result side: random stalls plus a long hold-off every few hundred requests
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (accepted_count >= next_hold_at) begin
      out_tready   <= 1'b0;
      hold_left    <= HOLD_CYCLES - 1;
      next_hold_at <= next_hold_at + HOLD_SPACING;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(15, 0))
      0:       return CMIN;
      1:       return CMAX;
      2, 3:    return coord_t'($urandom);
      default: return coord_t'($urandom_range(32'h0020_0000, 0)) - coord_t'(32'h0010_0000);
    endcase
  endfunction

  function automatic logic [ELAPSED_W-1:0] rand_elapsed();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return ELAPSED_MAX;
      2:       return ELAPSED_W'($urandom_range(ELAPSED_MAX, 0));
      default: return ELAPSED_W'($urandom_range(2000, 0));
    endcase
  endfunction

  // one request, with random idle cycles in front of it
  task automatic send_request(action_t act, logic [ELAPSED_W-1:0] elapsed,
                              coord_t x, coord_t y, coord_t z);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_TDATA_W'({z, y, x, elapsed});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random();
    int      pick;
    action_t act;
    pick = $urandom_range(99, 0);
    act  = (pick < 50) ? ACT_TICK : (pick < 80) ? ACT_MOVE : (pick < 95) ? ACT_SET : ACT_IDLE;
    send_request(act, rand_elapsed(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // stop offering and let every result come back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [RATE_W-1:0] rate_lat, logic [RATE_W-1:0] rate_foc,
                              coord_t xl, coord_t xh, coord_t yl, coord_t yh,
                              coord_t zl, coord_t zh);
    cfg_write(REG_RATE_LATERAL, rate_lat);
    cfg_write(REG_RATE_FOCUS, rate_foc);
    cfg_write(REG_LIM_X_LOW, xl);
    cfg_write(REG_LIM_X_HIGH, xh);
    cfg_write(REG_LIM_Y_LOW, yl);
    cfg_write(REG_LIM_Y_HIGH, yh);
    cfg_write(REG_LIM_Z_LOW, zl);
    cfg_write(REG_LIM_Z_HIGH, zh);
    cfg_wr_en <= 1'b0;
  endtask

  // register setting for one random segment
  task automatic random_setting(int k);
    logic [RATE_W-1:0] rate_lat;
    logic [RATE_W-1:0] rate_foc;
    coord_t            lo [NUM_AXES];
    coord_t            hi [NUM_AXES];
    coord_t            a;
    coord_t            b;
    rate_lat = $urandom_range(32'h0040_0000, 0);
    rate_foc = $urandom_range(32'h0040_0000, 0);
    for (int i = 0; i < NUM_AXES; i++) begin
      a     = rand_coord();
      b     = rand_coord();
      lo[i] = (a < b) ? a : b;
      hi[i] = (a < b) ? b : a;
      // crossed limits
      if (k == 2) begin
        lo[i] = hi[i];
        hi[i] = (a < b) ? a : b;
      end
      // full coordinate range
      if (k == 0) begin
        lo[i] = CMIN;
        hi[i] = CMAX;
      end
    end
    case (k)
      0: begin
        rate_lat = RATE_MAX;
        rate_foc = RATE_MAX;
      end
      1: rate_foc = '0;
      3: begin
        rate_lat = $urandom;
        rate_foc = $urandom;
      end
      5: rate_lat = '0;
      default: ;
    endcase
    program_regs(rate_lat, rate_foc, lo[AXIS_X], hi[AXIS_X], lo[AXIS_Y], hi[AXIS_Y],
                 lo[AXIS_Z], hi[AXIS_Z]);
  endtask

  initial begin
    do @(posedge clk); while (!rst_n);

    // register reset values: zero rates, open limits
    send_request(ACT_TICK, '0, rand_coord(), rand_coord(), rand_coord());
    send_request(ACT_MOVE, '0, CMAX, CMIN, coord_t'(32'h1234_5678));
    // zero allowance still reports moved
    send_request(ACT_TICK, ELAPSED_MAX, rand_coord(), rand_coord(), rand_coord());
    send_request(ACT_IDLE, ELAPSED_MAX, rand_coord(), rand_coord(), rand_coord());

    // lateral step equals elapsed, focus at full rate, Y limits crossed
    settle();
    program_regs(32'h0001_0000, RATE_MAX, -1000, 1000, 500, -500, CMIN, CMAX);
    send_request(ACT_SET, ELAPSED_MAX, 0, 0, 0);
    send_request(ACT_MOVE, '0, 5000, 0, CMAX);
    send_request(ACT_TICK, '0, 0, 0, 0);
    send_request(ACT_TICK, 400, 0, 0, 0);
    // distance equal to the allowance moves one full step
    send_request(ACT_TICK, 100, 0, 0, 0);
    // saturated allowance snaps
    send_request(ACT_TICK, ELAPSED_MAX, 0, 0, 0);
    send_request(ACT_MOVE, '0, -5000, 600, CMIN);
    send_request(ACT_SET, ELAPSED_MAX, CMAX, CMIN, 7);
    send_request(ACT_TICK, 5, CMAX, CMAX, CMAX);
    send_request(ACT_MOVE, '0, -1000, 500, -7);
    send_request(ACT_TICK, ELAPSED_MAX, 0, 0, 0);
    // full-range Z travel against the saturated allowance
    send_request(ACT_SET, '0, 0, 0, CMIN);
    send_request(ACT_MOVE, '0, 1000, -500, CMAX);
    send_request(ACT_TICK, ELAPSED_MAX, CMIN, CMIN, CMIN);
    send_request(ACT_TICK, 1, 0, 0, 0);
    send_request(ACT_IDLE, ELAPSED_MAX, CMAX, CMIN, CMAX);

    // random traffic over three idling phases, two settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 9;
          rx_idle_pct = 59;
        end
        1: begin
          tx_idle_pct = 59;
          rx_idle_pct = 9;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 2; s++) begin
        settle();
        random_setting(2 * ph + s);
        repeat (ITEMS_PER_SEGMENT) send_random();
      end
    end

    settle();
    if (error_count == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
sv/tas_pkg.sv
sv/tas_lane.sv
sv/tas_merge.sv
sv/three_axis_slew_limited_stage.sv
bench/stage_motion_checker.sv
bench/tb_three_axis_slew_limited_stage.sv
